@@ rtl/sorted_table_insert_search_remove_assert.svh @@
// assertion macros for the sorted table block
// used by sorted_table_insert_search_remove.sv; expects i_clk and i_rst_n in scope
`ifndef SORTED_TABLE_INSERT_SEARCH_REMOVE_ASSERT_SVH
`define SORTED_TABLE_INSERT_SEARCH_REMOVE_ASSERT_SVH
`ifndef ASSERT_OFF
// checked while out of reset
`define STS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sorted table assertion failed");
// checked at every edge, reset included
`define STS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("sorted table assertion failed");
`else
`define STS_ASSERT(label, prop)
`define STS_ASSERT_ALWAYS(label, prop)
`endif
`endif

@@ rtl/sts_pkg.sv @@
// codes and field widths for the sorted table block
// no dependencies; used by sorted_table_insert_search_remove.sv
`timescale 1ns / 1ps
package sts_pkg;
    localparam int OP_W     = 2;
    localparam int VAL_W    = 16;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_op OP_SEARCH = 2'd0;
    localparam t_op OP_INSERT = 2'd1;
    localparam t_op OP_REMOVE = 2'd2;
    localparam t_op OP_SPARE  = 2'd3;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_NOT_FOUND = 3'd1;
    localparam t_status ST_EMPTY     = 3'd2;
    localparam t_status ST_FULL      = 3'd3;
    localparam t_status ST_DUPLICATE = 3'd4;
endpackage

@@ rtl/sorted_table_insert_search_remove.sv @@
// sorted table: a search makes up to k = ceil(log2(n+1)) probes of the n entries;
// an insert then moves entries up to open a slot, a remove moves entries down to close one;
// empty or full refusals skip the search and go straight to the result; one item at a time,
// busy high until the result cycle; each probe is a read state then a compare state;
// result strobe lasts one cycle and cannot be stalled; synchronous active-low reset
// clears counts and control, table contents stay undefined until written
`timescale 1ns / 1ps
`include "sorted_table_insert_search_remove_assert.svh"
module sorted_table_insert_search_remove #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sts_pkg::OP_W-1:0]      i_operation,
    input  logic signed [sts_pkg::VAL_W-1:0] i_value,
    output logic                          o_strobe,
    output logic [sts_pkg::STATUS_W-1:0]  o_status,
    output logic [sts_pkg::POS_W-1:0]     o_position,
    output logic [sts_pkg::COUNT_W-1:0]   o_table_count
);
    // index, count and memory address widths
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = IW + 1;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;   // issue probe read or finish search
    localparam logic [2:0] S_CMP  = 3'd2;   // compare probe with value
    localparam logic [2:0] S_SHUP = 3'd3;   // move entries up for insert
    localparam logic [2:0] S_SHDN = 3'd4;   // move entries down for remove
    localparam logic [2:0] S_WRV  = 3'd5;   // write new value into its slot
    localparam logic [2:0] S_DONE = 3'd6;   // update count, emit result

    logic [2:0]                    r_state;
    sts_pkg::t_op                  r_op;
    logic signed [sts_pkg::VAL_W-1:0] r_val;
    logic                          r_sel;     // 1 selects the negative table
    logic [CW-1:0]                 r_n;       // count of the selected table
    logic [CW-1:0]                 r_lo;
    logic [CW-1:0]                 r_hi;
    logic [IW-1:0]                 r_mid;
    logic                          r_hit;     // probe matched the value
    logic [CW-1:0]                 r_ptr;     // shift pointer
    logic                          r_wpend;   // shift write waiting on read data
    logic [IW-1:0]                 r_waddr;
    sts_pkg::t_status              r_status;
    logic [CW-1:0]                 r_cnt_pos;
    logic [CW-1:0]                 r_cnt_neg;

    // both tables share one memory, table select is the top address bit
    logic [sts_pkg::VAL_W-1:0]     r_mem [0:(1<<AW)-1];
    logic signed [sts_pkg::VAL_W-1:0] r_rdata;

    logic [CW:0]                   w_sum;
    logic [IW-1:0]                 w_mid;
    logic [CW-1:0]                 w_ptr_m1;
    logic [IW-1:0]                 w_rd_idx;
    logic                          w_we;
    logic [IW-1:0]                 w_wr_idx;
    logic [sts_pkg::VAL_W-1:0]     w_wdata;
    logic [CW-1:0]                 w_cnt_in;
    logic [CW-1:0]                 w_new_n;

    assign busy     = (r_state != S_IDLE);
    assign w_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid    = w_sum[IW:1];
    assign w_ptr_m1 = r_ptr - CW'(1);
    assign w_cnt_in = i_value[sts_pkg::VAL_W-1] ? r_cnt_neg : r_cnt_pos;

    // read address: probe during search, source entry during a shift
    always_comb begin
        unique case (r_state)
            S_SHUP:  w_rd_idx = w_ptr_m1[IW-1:0];
            S_SHDN:  w_rd_idx = r_ptr[IW-1:0];
            default: w_rd_idx = w_mid;
        endcase
    end

    // write port: delayed shift beat, or the new value
    always_comb begin
        w_we     = 1'b0;
        w_wr_idx = r_waddr;
        w_wdata  = r_rdata;
        if (r_state == S_WRV) begin
            w_we     = 1'b1;
            w_wr_idx = r_lo[IW-1:0];
            w_wdata  = r_val;
        end else if ((r_state == S_SHUP || r_state == S_SHDN) && r_wpend) begin
            w_we = 1'b1;
        end
    end

    // count after the operation
    always_comb begin
        w_new_n = r_n;
        if (r_status == sts_pkg::ST_OK) begin
            if (r_op == sts_pkg::OP_INSERT) begin
                w_new_n = r_n + CW'(1);
            end else if (r_op == sts_pkg::OP_REMOVE) begin
                w_new_n = r_n - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[{r_sel, w_wr_idx}] <= w_wdata;
        end
        r_rdata <= r_mem[{r_sel, w_rd_idx}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wpend   <= 1'b0;
            r_cnt_pos <= '0;
            r_cnt_neg <= '0;
            o_strobe  <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op    <= i_operation;
                        r_val   <= i_value;
                        r_sel   <= i_value[sts_pkg::VAL_W-1];
                        r_n     <= w_cnt_in;
                        r_lo    <= '0;
                        r_hi    <= w_cnt_in;
                        r_hit   <= 1'b0;
                        r_wpend <= 1'b0;
                        // full check comes before any search
                        if (i_operation == sts_pkg::OP_INSERT &&
                            w_cnt_in >= CW'(TABLE_DEPTH)) begin
                            r_status <= sts_pkg::ST_FULL;
                            r_state  <= S_DONE;
                        end else if (i_operation != sts_pkg::OP_INSERT &&
                                     w_cnt_in == '0) begin
                            r_status <= sts_pkg::ST_EMPTY;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= w_mid;
                        r_state <= S_CMP;
                    end else begin
                        // r_lo is the lower bound, r_hit says it holds the value
                        unique case (r_op)
                            sts_pkg::OP_INSERT: begin
                                if (r_hit) begin
                                    r_status <= sts_pkg::ST_DUPLICATE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= sts_pkg::ST_OK;
                                    r_ptr    <= r_n;
                                    r_state  <= S_SHUP;
                                end
                            end
                            sts_pkg::OP_REMOVE: begin
                                if (r_hit) begin
                                    r_status <= sts_pkg::ST_OK;
                                    r_ptr    <= r_lo + CW'(1);
                                    r_state  <= S_SHDN;
                                end else begin
                                    r_status <= sts_pkg::ST_NOT_FOUND;
                                    r_state  <= S_DONE;
                                end
                            end
                            default: begin
                                // search, spare code acts as search
                                r_status <= r_hit ? sts_pkg::ST_OK : sts_pkg::ST_NOT_FOUND;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_CMP: begin
                    if (r_rdata < r_val) begin
                        r_lo <= CW'(r_mid) + CW'(1);
                    end else begin
                        r_hi <= CW'(r_mid);
                    end
                    if (r_rdata == r_val) begin
                        r_hit <= 1'b1;
                    end
                    r_state <= S_RD;
                end
                S_SHUP: begin
                    // read entry ptr-1, write it to ptr on the next beat
                    if (r_ptr > r_lo) begin
                        r_waddr <= r_ptr[IW-1:0];
                        r_wpend <= 1'b1;
                        r_ptr   <= w_ptr_m1;
                    end else begin
                        r_wpend <= 1'b0;
                        r_state <= S_WRV;
                    end
                end
                S_SHDN: begin
                    // read entry ptr, write it to ptr-1 on the next beat
                    if (r_ptr < r_n) begin
                        r_waddr <= w_ptr_m1[IW-1:0];
                        r_wpend <= 1'b1;
                        r_ptr   <= r_ptr + CW'(1);
                    end else begin
                        r_wpend <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_WRV: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (r_sel) begin
                        r_cnt_neg <= w_new_n;
                    end else begin
                        r_cnt_pos <= w_new_n;
                    end
                    o_strobe      <= 1'b1;
                    o_status      <= r_status;
                    o_position    <= (r_status == sts_pkg::ST_OK) ?
                                     sts_pkg::POS_W'(r_lo) : '0;
                    o_table_count <= sts_pkg::COUNT_W'(w_new_n);
                    r_state       <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result only follows the done step
    `STS_ASSERT(a_strobe_after_done, o_strobe |-> $past(r_state) == S_DONE)
    // a taken request keeps the block busy
    `STS_ASSERT(a_busy_after_start, (start && !busy) |=> busy)
    // counts stay within the table
    `STS_ASSERT(a_count_range,
        r_cnt_pos <= CW'(TABLE_DEPTH) && r_cnt_neg <= CW'(TABLE_DEPTH))
    // failed requests report position zero
    `STS_ASSERT(a_pos_zero_on_fail,
        (o_strobe && o_status != sts_pkg::ST_OK) |-> o_position == '0)
endmodule
